### rtl/text_console_writer_defines.svh
// Assertion macros shared by the console RTL.
// Each macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Condition holds at every edge.
`define TCW_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequence holds in the same cycle as the trigger.
`define TCW_ASSERT_IMPLIES(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cons)) else $error(msg);

// Consequence holds in the cycle after the trigger.
`define TCW_ASSERT_NEXT(label, trig, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) else $error(msg);

`endif

### rtl/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

   localparam int CELL_W = 16;
   localparam int POS_W  = 11;

   localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;
   localparam logic [7:0]        CELL_ATTR  = 8'h0F;

   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_RETURN    = 8'd13;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;

   localparam logic [1:0] REQ_PUT   = 2'd0;
   localparam logic [1:0] REQ_CLEAR = 2'd1;
   localparam logic [1:0] REQ_SET   = 2'd2;
   localparam logic [1:0] REQ_READ  = 2'd3;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] char_code;
      logic [6:0] col;
      logic [4:0] row;
   } tcw_req_type;

   typedef struct packed {
      logic [POS_W-1:0]  cursor_pos;
      logic [CELL_W-1:0] cell_data;
   } tcw_rsp_type;

endpackage

`default_nettype wire

### rtl/tcw_cell_store.sv
`default_nettype none

module tcw_cell_store #(
   parameter int DEPTH = 2000,
   parameter int AW    = 11
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [tcw_pkg::CELL_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [AW-1:0]              rd_addr,
   output      logic [tcw_pkg::CELL_W-1:0] rd_data
);
   import tcw_pkg::*;

   logic [CELL_W-1:0] mem [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/text_console_writer.sv
// Channel   Ports                                   Direction
// request   req_valid, req_stall, req_word          in (req_stall out)
// response  rsp_valid, rsp_stall, rsp_word          out (rsp_stall in)
//
// Put, set cursor and read first accept the word and form the address, then make
// one cell memory access. A scrolling put then blanks the row leaving the top,
// one write per cell (rows sit on a circular base, so nothing is copied).
// Clear screen blanks the whole memory, one memory write per cell.
// After reset req_stall stays high while the memory is blanked. A stalled
// response holds while the next request is accepted.
`default_nettype none
`include "text_console_writer_defines.svh"

module text_console_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire tcw_pkg::tcw_req_type req_word,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      tcw_pkg::tcw_rsp_type rsp_word
);
   import tcw_pkg::*;

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_ACCESS = 3'b010,
      ST_SWEEP  = 3'b100
   } tcw_state_type;

   tcw_state_type     state_ff, state_in;
   logic [AW-1:0]     sweep_ff, sweep_in;
   logic [AW-1:0]     sweep_end_ff, sweep_end_in;
   logic              pend_ff, pend_in;
   logic [CW-1:0]     cur_col_ff, cur_col_in;
   logic [RW-1:0]     cur_row_ff, cur_row_in;
   logic [AW-1:0]     top_base_ff, top_base_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic              we_ff, we_in;
   logic [CELL_W-1:0] wdata_ff, wdata_in;
   logic              is_read_ff, is_read_in;
   logic              scroll_ff, scroll_in;
   logic              rsp_valid_ff, rsp_valid_in;
   tcw_rsp_type       rsp_ff, rsp_in;

   logic              out_free;
   logic              deliver;
   logic              accept;
   logic [CW-1:0]     col_cl;
   logic [RW-1:0]     row_cl;
   logic [CW:0]       put_col;
   logic [RW:0]       put_row;
   logic [CW-1:0]     put_tgt_col;
   logic              put_we;
   logic [CELL_W-1:0] put_wdata;
   logic              put_scroll;
   logic [CW-1:0]     tgt_col;
   logic [RW-1:0]     tgt_row;
   logic [AW:0]       lin_addr;
   logic [AW:0]       sum_addr;
   logic [AW-1:0]     cell_addr;
   logic [AW:0]       tb_next;
   logic [15:0]       pos_full;

   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [CELL_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [CELL_W-1:0] mem_rd_data;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || (pend_ff && !out_free);
   assign accept    = req_valid && !req_stall;
   assign deliver   = (state_ff == ST_IDLE) && pend_ff && out_free;

   assign col_cl = ({2'b00, req_word.col} > 9'(COLUMNS - 1)) ? CW'(COLUMNS - 1)
                                                             : CW'(req_word.col);
   assign row_cl = ({3'b000, req_word.row} > 8'(ROWS - 1)) ? RW'(ROWS - 1)
                                                           : RW'(req_word.row);

   // Cursor motion for a put, including wrap and scroll.
   always_comb begin
      put_col     = {1'b0, cur_col_ff};
      put_row     = {1'b0, cur_row_ff};
      put_tgt_col = cur_col_ff;
      put_we      = 1'b0;
      put_wdata   = BLANK_CELL;
      if (req_word.char_code == CH_NEWLINE) begin
         put_col = '0;
         put_row = put_row + (RW+1)'(1);
      end else if (req_word.char_code == CH_RETURN) begin
         put_col = '0;
      end else if (req_word.char_code == CH_BACKSPACE) begin
         if (cur_col_ff != '0) begin
            put_col     = put_col - (CW+1)'(1);
            put_tgt_col = cur_col_ff - CW'(1);
            put_we      = 1'b1;
         end
      end else begin
         put_we    = 1'b1;
         put_wdata = {CELL_ATTR, req_word.char_code};
         put_col   = put_col + (CW+1)'(1);
      end
      if (put_col == (CW+1)'(COLUMNS)) begin
         put_col = '0;
         put_row = put_row + (RW+1)'(1);
      end
      put_scroll = (put_row == (RW+1)'(ROWS));
      if (put_scroll) begin
         put_row = (RW+1)'(ROWS - 1);
      end
   end

   // Map logical row and column onto the circular cell memory.
   assign tgt_col   = (req_word.req_type == REQ_READ) ? col_cl : put_tgt_col;
   assign tgt_row   = (req_word.req_type == REQ_READ) ? row_cl : cur_row_ff;
   assign lin_addr  = (AW+1)'(tgt_row) * (AW+1)'(COLUMNS) + (AW+1)'(tgt_col);
   assign sum_addr  = (AW+1)'(top_base_ff) + lin_addr;
   assign cell_addr = (sum_addr >= (AW+1)'(CELLS)) ? AW'(sum_addr - (AW+1)'(CELLS))
                                                   : AW'(sum_addr);
   assign tb_next   = (AW+1)'(top_base_ff) + (AW+1)'(COLUMNS);

   assign pos_full = 16'(cur_row_ff) * 16'(COLUMNS) + 16'(cur_col_ff);

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      sweep_end_in = sweep_end_ff;
      pend_in      = pend_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      top_base_in  = top_base_ff;
      addr_in      = addr_ff;
      we_in        = we_ff;
      wdata_in     = wdata_ff;
      is_read_in   = is_read_ff;
      scroll_in    = scroll_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (deliver) begin
         rsp_valid_in      = 1'b1;
         rsp_in.cursor_pos = pos_full[POS_W-1:0];
         rsp_in.cell_data  = is_read_ff ? mem_rd_data : '0;
         pend_in           = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pend_in    = 1'b1;
               addr_in    = cell_addr;
               we_in      = 1'b0;
               wdata_in   = put_wdata;
               is_read_in = 1'b0;
               scroll_in  = 1'b0;
               state_in   = ST_ACCESS;
               case (req_word.req_type)
                  REQ_PUT: begin
                     cur_col_in = CW'(put_col);
                     cur_row_in = RW'(put_row);
                     we_in      = put_we;
                     scroll_in  = put_scroll;
                     if (put_scroll) begin
                        // blank the old top row, then make the next row the top
                        sweep_in     = top_base_ff;
                        sweep_end_in = AW'(tb_next - (AW+1)'(1));
                        top_base_in  = (tb_next == (AW+1)'(CELLS)) ? '0 : AW'(tb_next);
                     end
                  end
                  REQ_CLEAR: begin
                     cur_col_in   = '0;
                     cur_row_in   = '0;
                     top_base_in  = '0;
                     sweep_in     = '0;
                     sweep_end_in = AW'(CELLS - 1);
                     state_in     = ST_SWEEP;
                  end
                  REQ_SET: begin
                     cur_col_in = col_cl;
                     cur_row_in = row_cl;
                  end
                  REQ_READ: begin
                     is_read_in = 1'b1;
                  end
                  default: begin
                     state_in = ST_ACCESS;
                  end
               endcase
            end
         end
         ST_ACCESS: begin
            state_in = scroll_ff ? ST_SWEEP : ST_IDLE;
         end
         ST_SWEEP: begin
            if (sweep_ff == sweep_end_ff) begin
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + AW'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         sweep_end_ff <= AW'(CELLS - 1);
         pend_ff      <= 1'b0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         top_base_ff  <= '0;
         we_ff        <= 1'b0;
         is_read_ff   <= 1'b0;
         scroll_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         sweep_end_ff <= sweep_end_in;
         pend_ff      <= pend_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         top_base_ff  <= top_base_in;
         we_ff        <= we_in;
         is_read_ff   <= is_read_in;
         scroll_ff    <= scroll_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff  <= addr_in;
      wdata_ff <= wdata_in;
      rsp_ff   <= rsp_in;
   end

   assign mem_wr_en   = (state_ff == ST_SWEEP) || ((state_ff == ST_ACCESS) && we_ff);
   assign mem_wr_addr = (state_ff == ST_SWEEP) ? sweep_ff : addr_ff;
   assign mem_wr_data = (state_ff == ST_SWEEP) ? BLANK_CELL : wdata_ff;
   assign mem_rd_en   = (state_ff == ST_ACCESS) && is_read_ff;

   tcw_cell_store #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_cell_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (addr_ff),
      .rd_data (mem_rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   `TCW_ASSERT_HOLDS(a_cursor_range, (cur_col_ff < COLUMNS) && (cur_row_ff < ROWS),
                     "cursor out of grid")
   `TCW_ASSERT_HOLDS(a_top_base_range, top_base_ff < CELLS, "row base beyond memory")
   `TCW_ASSERT_IMPLIES(a_sweep_bound, state_ff == ST_SWEEP, sweep_ff <= sweep_end_ff,
                       "sweep past end")
   `TCW_ASSERT_NEXT(a_accept_access, accept && (req_word.req_type != REQ_CLEAR),
                    (state_ff == ST_ACCESS) && pend_ff, "accepted word lost")

endmodule

`default_nettype wire
